[hw/rtl/cpcq_pkg.sv]
// Shared types, constants and a helper function of the pending-command queue.
package cpcq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QD_W        = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 63;
	localparam int DRIFT_W     = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_NODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_NODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_COMMAND   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIFT      = 2'd3;

	localparam logic [7:0]         RST_UNKNOWN_NODE   = 8'd0;
	localparam logic [7:0]         RST_BROADCAST_NODE = 8'd255;
	localparam logic [7:0]         RST_SYNC_COMMAND   = 8'd0;
	localparam logic [DRIFT_W-1:0] RST_MAX_DRIFT      = 32'd5000;

	localparam logic              REQ_PUSH = 1'b0;
	localparam logic              REQ_WAKE = 1'b1;

	typedef struct packed {
		logic [7:0]  node;
		logic [7:0]  cmd;
		logic        ack;
		logic [15:0] handle;
		logic [7:0]  len;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic calc_drift;
		logic decide;
		logic scan_init;
		logic pscan;
		logic place;
		logic cscan;
		logic finish;
	} cpcq_cmd_t;

	typedef struct packed {
		logic is_wake;
		logic refused;
		logic armed_now;
		logic pscan_done;
		logic cscan_done;
		logic fin_done;
	} cpcq_sts_t;

	// Physical slot of logical position k, counted from the head.
	function automatic logic [QD_W-1:0] qpos(input logic [QD_W-1:0] h,
			input logic [CNT_W-1:0] k);
		logic [CNT_W:0] s;
		s = {{(CNT_W + 1 - QD_W){1'b0}}, h} + {1'b0, k};
		if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
			s = s - (CNT_W + 1)'(QUEUE_DEPTH);
		end
		return s[QD_W-1:0];
	endfunction

endpackage

[hw/rtl/cpcq_ctrl.sv]
// Sequencing state machine of the pending-command queue.
module cpcq_ctrl import cpcq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  cpcq_sts_t sts,
	output cpcq_cmd_t ctl
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DRIFT = 3'd1;
	localparam logic [2:0] ST_DEC   = 3'd2;
	localparam logic [2:0] ST_PSCAN = 3'd3;
	localparam logic [2:0] ST_PLACE = 3'd4;
	localparam logic [2:0] ST_CSCAN = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		ctl       = '0;
		state_d   = state_q;
		req_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ctl.capture = 1'b1;
					state_d     = ST_DRIFT;
				end
			end
			ST_DRIFT: begin
				ctl.calc_drift = 1'b1;
				state_d        = ST_DEC;
			end
			ST_DEC: begin
				ctl.decide    = 1'b1;
				ctl.scan_init = 1'b1;
				if (!sts.is_wake) begin
					state_d = sts.refused ? ST_FIN : ST_PSCAN;
				end else begin
					state_d = (sts.armed_now && !sts.refused) ? ST_PSCAN : ST_CSCAN;
				end
			end
			ST_PSCAN: begin
				ctl.pscan = 1'b1;
				if (sts.pscan_done) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				ctl.place     = 1'b1;
				ctl.scan_init = 1'b1;
				state_d       = sts.is_wake ? ST_CSCAN : ST_FIN;
			end
			ST_CSCAN: begin
				ctl.cscan = 1'b1;
				if (sts.cscan_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				ctl.finish = 1'b1;
				if (sts.fin_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/cpcq_dp.sv]
// Datapath of the pending-command queue: entry memory, scan pipeline and result register.
module cpcq_dp import cpcq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_type,
	input  logic [7:0]            node_id,
	input  logic [7:0]            command,
	input  logic                  need_ack,
	input  logic [15:0]           payload_handle,
	input  logic [7:0]            payload_bytes,
	input  logic [TIME_W-1:0]     node_time_ms,
	input  logic [TIME_W-1:0]     local_time_ms,
	input  logic                  local_synced,
	input  cpcq_cmd_t             ctl,
	output cpcq_sts_t             sts,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  accepted,
	output logic                  replaced_existing,
	output logic                  dropped_oldest,
	output logic                  sync_armed,
	output logic                  item_valid,
	output logic [7:0]            out_node_id,
	output logic [7:0]            out_command,
	output logic                  out_need_ack,
	output logic [15:0]           out_payload_handle,
	output logic [7:0]            out_payload_bytes,
	output logic                  last
);

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	logic [7:0]         unk_q;
	logic [7:0]         bcast_q;
	logic [7:0]         sync_cmd_q;
	logic [DRIFT_W-1:0] max_drift_q;

	logic              type_q;
	entry_t            in_e_q;
	logic [TIME_W-1:0] nt_q;
	logic [TIME_W-1:0] rt_q;
	logic              synced_q;
	logic [TIME_W-1:0] drift_q;
	entry_t            new_q;
	logic              acc_q;
	logic              rep_q;
	logic              drop_q;
	logic              armed_q;

	logic [QD_W-1:0]  head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_k_q;
	logic [CNT_W-1:0] nk_q;
	logic             rdv_s1;
	logic [QD_W-1:0]  addr_s1;
	entry_t           rd_e_s1;
	logic             pend_v_q;
	entry_t           pend_e_q;
	logic             out_v_q;
	entry_t           out_e_q;
	logic             out_acc_q;
	logic             out_rep_q;
	logic             out_drop_q;
	logic             out_armed_q;
	logic             out_iv_q;
	logic             out_last_q;

	entry_t mem [QUEUE_DEPTH];

	logic              hit;
	logic              nmatch;
	logic              more;
	logic              full;
	logic              cgo;
	logic              re;
	logic [QD_W-1:0]   raddr;
	logic              we;
	logic [QD_W-1:0]   waddr;
	entry_t            wdata;
	logic              emit_load;
	logic              fin_load;
	logic [TIME_W:0]   d_fwd;
	logic [TIME_W-1:0] d_bwd;
	logic              armed_now;

	assign cfg_ready = 1'b1;

	assign hit    = rdv_s1 && (rd_e_s1.node == new_q.node) && (rd_e_s1.cmd == new_q.cmd);
	assign nmatch = rdv_s1 && (rd_e_s1.node == in_e_q.node);
	assign more   = (rd_k_q != count_q);
	assign full   = (count_q == DEPTH_C);
	// The compaction scan halts while a second removed entry finds the result register busy.
	assign cgo    = !(nmatch && pend_v_q && out_v_q && !rsp_ready);
	assign re     = (ctl.pscan && !hit && more) || (ctl.cscan && cgo && more);
	assign raddr  = qpos(head_q, rd_k_q);

	assign emit_load = ctl.cscan && cgo && nmatch && pend_v_q;
	assign fin_load  = ctl.finish && (!out_v_q || rsp_ready);

	assign d_fwd     = {1'b0, rt_q} - {1'b0, nt_q};
	assign d_bwd     = nt_q - rt_q;
	assign armed_now = synced_q &&
		((nt_q == '0) || (drift_q > {{(TIME_W - DRIFT_W){1'b0}}, max_drift_q}));

	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = new_q;
		if (ctl.pscan && hit) begin
			we = 1'b1;
		end else if (ctl.place && !rep_q) begin
			we    = 1'b1;
			waddr = full ? head_q : qpos(head_q, count_q);
		end else if (ctl.cscan && cgo && rdv_s1 && !nmatch) begin
			we    = 1'b1;
			waddr = qpos(head_q, nk_q);
			wdata = rd_e_s1;
		end
	end

	always_comb begin
		sts            = '0;
		sts.is_wake    = (type_q == REQ_WAKE);
		sts.refused    = (in_e_q.node == unk_q) || (in_e_q.node == bcast_q);
		sts.armed_now  = armed_now;
		sts.pscan_done = hit || (!rdv_s1 && !more);
		sts.cscan_done = !rdv_s1 && !more;
		sts.fin_done   = !out_v_q || rsp_ready;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_e_s1 <= mem[raddr];
			addr_s1 <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unk_q       <= RST_UNKNOWN_NODE;
			bcast_q     <= RST_BROADCAST_NODE;
			sync_cmd_q  <= RST_SYNC_COMMAND;
			max_drift_q <= RST_MAX_DRIFT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_UNKNOWN_NODE:   unk_q       <= cfg_data[7:0];
				REG_BROADCAST_NODE: bcast_q     <= cfg_data[7:0];
				REG_SYNC_COMMAND:   sync_cmd_q  <= cfg_data[7:0];
				REG_MAX_DRIFT:      max_drift_q <= cfg_data[DRIFT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			type_q   <= req_type;
			in_e_q   <= '{node: node_id, cmd: command, ack: need_ack,
				handle: payload_handle, len: payload_bytes};
			nt_q     <= node_time_ms;
			rt_q     <= local_time_ms;
			synced_q <= local_synced;
			acc_q    <= 1'b0;
			rep_q    <= 1'b0;
			drop_q   <= 1'b0;
			armed_q  <= 1'b0;
		end
		if (ctl.calc_drift) begin
			drift_q <= d_fwd[TIME_W] ? d_bwd : d_fwd[TIME_W-1:0];
		end
		if (ctl.decide) begin
			if (type_q == REQ_WAKE) begin
				new_q   <= '{node: in_e_q.node, cmd: sync_cmd_q, ack: 1'b0,
					handle: 16'd0, len: 8'd0};
				armed_q <= armed_now;
				acc_q   <= armed_now && !sts.refused;
			end else begin
				new_q <= in_e_q;
				acc_q <= !sts.refused;
			end
		end
		if (ctl.pscan && hit) begin
			rep_q <= 1'b1;
		end
		if (ctl.place && !rep_q && full) begin
			drop_q <= 1'b1;
		end
		if (ctl.cscan && cgo && nmatch) begin
			pend_e_q <= rd_e_s1;
		end
		if (emit_load || fin_load) begin
			out_acc_q   <= acc_q;
			out_rep_q   <= rep_q;
			out_drop_q  <= drop_q;
			out_armed_q <= armed_q;
			if (emit_load) begin
				out_e_q    <= pend_e_q;
				out_iv_q   <= 1'b1;
				out_last_q <= 1'b0;
			end else begin
				out_e_q    <= pend_v_q ? pend_e_q : '0;
				out_iv_q   <= pend_v_q;
				out_last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			rd_k_q   <= '0;
			nk_q     <= '0;
			rdv_s1   <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.scan_init) begin
				rd_k_q <= '0;
				nk_q   <= '0;
				rdv_s1 <= 1'b0;
			end else if (ctl.pscan) begin
				rdv_s1 <= re;
				if (re) begin
					rd_k_q <= rd_k_q + ONE_C;
				end
			end else if (ctl.cscan && cgo) begin
				rdv_s1 <= re;
				if (re) begin
					rd_k_q <= rd_k_q + ONE_C;
				end
				if (rdv_s1 && !nmatch) begin
					nk_q <= nk_q + ONE_C;
				end
				if (sts.cscan_done) begin
					count_q <= nk_q;
				end
			end
			if (ctl.place && !rep_q) begin
				if (full) begin
					head_q <= qpos(head_q, ONE_C);
				end else begin
					count_q <= count_q + ONE_C;
				end
			end
			if (ctl.cscan && cgo && nmatch) begin
				pend_v_q <= 1'b1;
			end else if (fin_load) begin
				pend_v_q <= 1'b0;
			end
			if (emit_load || fin_load) begin
				out_v_q <= 1'b1;
			end else if (rsp_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign rsp_valid          = out_v_q;
	assign accepted           = out_acc_q;
	assign replaced_existing  = out_rep_q;
	assign dropped_oldest     = out_drop_q;
	assign sync_armed         = out_armed_q;
	assign item_valid         = out_iv_q;
	assign out_node_id        = out_e_q.node;
	assign out_command        = out_e_q.cmd;
	assign out_need_ack       = out_e_q.ack;
	assign out_payload_handle = out_e_q.handle;
	assign out_payload_bytes  = out_e_q.len;
	assign last               = out_last_q;

endmodule

[hw/rtl/coalescing_pending_command_queue_top.sv]
// Top level of the coalescing pending-command queue.
// A push replaces a queued entry of the same node and command, or is appended; a refused
// push skips the scan. A wake gives its final result after the removal scan, which an armed
// time-sync push precedes; a busy result register stalls the removal scan and final result.
// One item at a time: the next is accepted the cycle after the final result is loaded.
// Reset clears head, count and control state at once; memory contents are left undefined.
module coalescing_pending_command_queue_top import cpcq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic                  req_type,
	input  logic [7:0]            node_id,
	input  logic [7:0]            command,
	input  logic                  need_ack,
	input  logic [15:0]           payload_handle,
	input  logic [7:0]            payload_bytes,
	input  logic [TIME_W-1:0]     node_time_ms,
	input  logic [TIME_W-1:0]     local_time_ms,
	input  logic                  local_synced,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  accepted,
	output logic                  replaced_existing,
	output logic                  dropped_oldest,
	output logic                  sync_armed,
	output logic                  item_valid,
	output logic [7:0]            out_node_id,
	output logic [7:0]            out_command,
	output logic                  out_need_ack,
	output logic [15:0]           out_payload_handle,
	output logic [7:0]            out_payload_bytes,
	output logic                  last
);

	cpcq_cmd_t ctl;
	cpcq_sts_t sts;

	cpcq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	cpcq_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.req_type           (req_type),
		.node_id            (node_id),
		.command            (command),
		.need_ack           (need_ack),
		.payload_handle     (payload_handle),
		.payload_bytes      (payload_bytes),
		.node_time_ms       (node_time_ms),
		.local_time_ms      (local_time_ms),
		.local_synced       (local_synced),
		.ctl                (ctl),
		.sts                (sts),
		.rsp_valid          (rsp_valid),
		.rsp_ready          (rsp_ready),
		.accepted           (accepted),
		.replaced_existing  (replaced_existing),
		.dropped_oldest     (dropped_oldest),
		.sync_armed         (sync_armed),
		.item_valid         (item_valid),
		.out_node_id        (out_node_id),
		.out_command        (out_command),
		.out_need_ack       (out_need_ack),
		.out_payload_handle (out_payload_handle),
		.out_payload_bytes  (out_payload_bytes),
		.last               (last)
	);

endmodule

[hw/rtl/cpcq_checker.sv]
// Port-level assertions of the pending-command queue and their binding to the top level.
module cpcq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       accepted,
	input logic       replaced_existing,
	input logic       dropped_oldest,
	input logic       item_valid,
	input logic [7:0] out_node_id,
	input logic [7:0] out_command,
	input logic       last
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result item withdrawn before it was taken");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !item_valid |-> last && (out_node_id == 8'd0) && (out_command == 8'd0))
		else $error("item without an entry is not a clean final result");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (replaced_existing || dropped_oldest) |->
			accepted && !(replaced_existing && dropped_oldest))
		else $error("replace or drop reported without an accepted push");

	a_not_last_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> item_valid)
		else $error("non-final result carries no entry");

endmodule

bind coalescing_pending_command_queue_top cpcq_checker u_cpcq_checker (.*);
